>>> src/aaw_pkg.sv
// Shared types and constants for the wrapping angle approach block.
package aaw_pkg;

	localparam int ANGLE_W  = 16;
	localparam int CFG_W    = 15;
	localparam int CFG_IDX_W = 2;
	localparam int DIV_STEPS = ANGLE_W;
	localparam int CNT_W    = $clog2(DIV_STEPS);

	localparam logic [CFG_IDX_W-1:0] REG_DIVISOR  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_STEP = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_STEP = 2'd2;

	localparam logic [CFG_W-1:0] DIVISOR_RST  = 15'd4;
	localparam logic [CFG_W-1:0] MAX_STEP_RST = 15'd1024;
	localparam logic [CFG_W-1:0] MIN_STEP_RST = 15'd16;

	localparam logic CMD_STEP = 1'b0;
	localparam logic CMD_LOAD = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_APPLY,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic capture;
		logic div_step;
		logic apply;
	} dp_cmd_t;

	typedef struct packed {
		logic is_load;
		logic at_target;
	} dp_stat_t;

endpackage

>>> src/aaw_ctrl.sv
// Controller state machine: sequences capture, serial division, update and output.
module aaw_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	input  aaw_pkg::dp_stat_t stat,
	output aaw_pkg::dp_cmd_t  cmd
);
	import aaw_pkg::*;

	state_t           state_q;
	state_t           state_nxt;
	logic [CNT_W-1:0] cnt_q;
	logic             div_last;

	assign div_last = (cnt_q == CNT_W'(DIV_STEPS - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_nxt;
			if (state_q == ST_IDLE) begin
				cnt_q <= '0;
			end else if (state_q == ST_DIV) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end
		end
	end

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					if (stat.is_load || stat.at_target) begin
						state_nxt = ST_OUT;
					end else begin
						state_nxt = ST_DIV;
					end
				end
			end
			ST_DIV: begin
				if (div_last) begin
					state_nxt = ST_APPLY;
				end
			end
			ST_APPLY: begin
				state_nxt = ST_OUT;
			end
			ST_OUT: begin
				if (out_ready) begin
					state_nxt = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		in_ready     = 1'b0;
		out_valid    = 1'b0;
		cmd.capture  = 1'b0;
		cmd.div_step = 1'b0;
		cmd.apply    = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready    = 1'b1;
				cmd.capture = in_valid;
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
			end
			ST_APPLY: begin
				cmd.apply = 1'b1;
			end
			ST_OUT: begin
				out_valid = 1'b1;
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

endmodule

>>> src/aaw_dp.sv
// Datapath: configuration registers, angle state, serial divider and step update.
module aaw_dp (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   cfg_we,
	input  logic [aaw_pkg::CFG_IDX_W-1:0]          cfg_index,
	input  logic [aaw_pkg::CFG_W-1:0]              cfg_wdata,
	input  logic                                   cmd_in,
	input  logic signed [aaw_pkg::ANGLE_W-1:0]     value,
	input  aaw_pkg::dp_cmd_t                       cmd,
	output aaw_pkg::dp_stat_t                      stat,
	output logic signed [aaw_pkg::ANGLE_W-1:0]     new_angle,
	output logic signed [aaw_pkg::ANGLE_W-1:0]     remaining
);
	import aaw_pkg::*;

	logic [CFG_W-1:0]   divisor_q;
	logic [CFG_W-1:0]   max_step_q;
	logic [CFG_W-1:0]   min_step_q;
	logic [ANGLE_W-1:0] angle_q;
	logic [ANGLE_W-1:0] tgt_q;
	logic               neg_q;
	logic [ANGLE_W-1:0] quo_q;
	logic [CFG_W-1:0]   rem_q;

	logic [ANGLE_W-1:0] diff_in;
	logic [ANGLE_W-1:0] div_eff;
	logic [ANGLE_W-1:0] trial;
	logic               trial_ge;
	logic [ANGLE_W-1:0] trial_sub;
	logic               min_path;
	logic [ANGLE_W-1:0] step_mag;
	logic [ANGLE_W-1:0] stepped;
	logic [ANGLE_W-1:0] left_after;
	logic               snap;
	logic [ANGLE_W-1:0] angle_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			divisor_q  <= DIVISOR_RST;
			max_step_q <= MAX_STEP_RST;
			min_step_q <= MIN_STEP_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_DIVISOR:  divisor_q  <= cfg_wdata;
				REG_MAX_STEP: max_step_q <= cfg_wdata;
				REG_MIN_STEP: min_step_q <= cfg_wdata;
				default:      divisor_q  <= divisor_q;
			endcase
		end
	end

	// Wrapped difference of the offered target against the held angle.
	assign diff_in        = value - angle_q;
	assign stat.is_load   = (cmd_in == CMD_LOAD);
	assign stat.at_target = (diff_in == '0);

	// One restoring division step per cycle on the magnitude of the difference.
	assign div_eff   = (divisor_q == '0) ? ANGLE_W'(1) : {1'b0, divisor_q};
	assign trial     = {rem_q, quo_q[ANGLE_W-1]};
	assign trial_ge  = (trial >= div_eff);
	assign trial_sub = trial - div_eff;

	// Update rule once the quotient magnitude sits in quo_q.
	assign min_path = (quo_q <= {1'b0, min_step_q});
	always_comb begin
		if (min_path) begin
			step_mag = {1'b0, min_step_q};
		end else if (quo_q > {1'b0, max_step_q}) begin
			step_mag = {1'b0, max_step_q};
		end else begin
			step_mag = quo_q;
		end
	end
	assign stepped    = neg_q ? (angle_q - step_mag) : (angle_q + step_mag);
	assign left_after = tgt_q - stepped;
	assign snap       = neg_q ? !left_after[ANGLE_W-1]
	                          : (left_after[ANGLE_W-1] || (left_after == '0));
	assign angle_nxt  = (min_path && snap) ? tgt_q : stepped;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			angle_q <= '0;
		end else if (cmd.capture && stat.is_load) begin
			angle_q <= value;
		end else if (cmd.apply) begin
			angle_q <= angle_nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			tgt_q <= value;
			neg_q <= diff_in[ANGLE_W-1];
			quo_q <= diff_in[ANGLE_W-1] ? (ANGLE_W'(0) - diff_in) : diff_in;
			rem_q <= '0;
		end else if (cmd.div_step) begin
			quo_q <= {quo_q[ANGLE_W-2:0], trial_ge};
			rem_q <= trial_ge ? trial_sub[CFG_W-1:0] : trial[CFG_W-1:0];
		end
	end

	// After a load or an item already on target the difference is zero by construction.
	assign new_angle = angle_q;
	assign remaining = tgt_q - angle_q;

endmodule

>>> src/angle_approach_wrapping.sv
// Top level of the wrapping angle approach block.
// The block holds one 16-bit wrapping angle and moves it toward a target word.
// Input channel (in_valid/in_ready) carries one word: cmd and value. With cmd
// set to load, value becomes the angle at once. With cmd set to step, value is
// the target: the wrapped difference is divided by the divisor register, and
// the angle moves by that quotient clamped to max_step, or, when the quotient
// is at most min_step, by min_step, snapping to a target it reaches or passes.
// Output channel (out_valid/out_ready) returns one word per input word: the
// new angle and the wrapped difference still left to the target.
// A load, or a step already on target, shows its result in the cycle after
// acceptance; a step first runs the divider iterations, then an update state,
// then the output state. The restoring divider yields one quotient bit per
// cycle. One word is in flight at a time, so the next word is accepted at the
// earliest in the cycle after its result is taken by the receiver.
// A stalled receiver holds the result steady and in_ready stays low until it
// is taken. Configuration writes (cfg_we, cfg_index, cfg_wdata) land at once.
// Reset clears the angle to zero and restores divisor 4, max_step 1024 and
// min_step 16; no word is pending afterwards.
module angle_approach_wrapping (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [aaw_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [aaw_pkg::CFG_W-1:0]          cfg_wdata,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic                               cmd,
	input  logic signed [aaw_pkg::ANGLE_W-1:0] value,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic signed [aaw_pkg::ANGLE_W-1:0] new_angle,
	output logic signed [aaw_pkg::ANGLE_W-1:0] remaining
);
	import aaw_pkg::*;

	dp_cmd_t  dp_cmd;
	dp_stat_t dp_stat;

	// The controller only sequences; all arithmetic lives in the datapath.
	aaw_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.stat      (dp_stat),
		.cmd       (dp_cmd)
	);

	aaw_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cmd_in    (cmd),
		.value     (value),
		.cmd       (dp_cmd),
		.stat      (dp_stat),
		.new_angle (new_angle),
		.remaining (remaining)
	);

endmodule

>>> tb/sv/testbench.sv
// Self-checking testbench for the wrapping angle approach block.
module testbench;
	import aaw_pkg::*;

	// The slowest correct run is roughly 1100 words with the longest gaps and stalls,
	// plus the long receiver hold. The limit sits many times above that.
	localparam int CYCLE_LIMIT = 500000;
	localparam int WORDS_PER_SETTING = 100;
	localparam int NUM_SETTINGS = 10;
	localparam int HOLD_CYCLES = 80;
	localparam int HOLD_AFTER = 400;
	localparam int TAIL_CYCLES = 40;

	// One result word as the block reports it.
	typedef struct packed {
		logic [ANGLE_W-1:0] angle;
		logic [ANGLE_W-1:0] rem;
	} angle_word_t;

	// A row of the directed script is either an input word or a register write.
	typedef enum logic {ROW_WORD, ROW_CFG} row_kind_t;

	typedef struct packed {
		row_kind_t            kind;
		logic [CFG_IDX_W-1:0] idx;
		logic                 op;
		logic [ANGLE_W-1:0]   data;
		logic                 typed;
		logic [ANGLE_W-1:0]   angle;
		logic [ANGLE_W-1:0]   rem;
	} dir_row_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0] cfg_wdata;
	logic in_valid;
	logic in_ready;
	logic cmd;
	logic signed [ANGLE_W-1:0] value;
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [ANGLE_W-1:0] new_angle;
	logic signed [ANGLE_W-1:0] remaining;

	// Our own copy of the block's state and registers, advanced on every
	// accepted word and on every register write we issue.
	logic [ANGLE_W-1:0] model_angle = '0;
	logic [CFG_W-1:0] div_reg = DIVISOR_RST;
	logic [CFG_W-1:0] max_reg = MAX_STEP_RST;
	logic [CFG_W-1:0] min_reg = MIN_STEP_RST;

	// Results still owed by the block, oldest first.
	angle_word_t pending_words [$];

	// Hand-typed expectation that goes with the word currently offered.
	logic typed_now = 1'b0;
	angle_word_t typed_word = '0;

	int mismatches = 0;
	int results_seen = 0;
	int loads_done = 0;
	int steps_done = 0;
	int cfg_writes = 0;
	int settings_used = 0;
	int cycle_count = 0;
	bit tx_idle = 1'b1;
	bit rx_idle = 1'b1;
	bit hold_done = 1'b0;

	// The directed script. Rows with typed set carry an expectation that can be
	// read straight off the behavior: loads, and steps that are already on target.
	// Everything else is left to the predictor.
	dir_row_t script [30] = '{
		// Fresh out of reset the angle is zero, so stepping to zero stays put.
		'{ROW_WORD, REG_DIVISOR, CMD_STEP, 16'h0000, 1'b1, 16'h0000, 16'h0000},
		'{ROW_WORD, REG_DIVISOR, CMD_LOAD, 16'h7FFF, 1'b1, 16'h7FFF, 16'h0000},
		'{ROW_WORD, REG_DIVISOR, CMD_STEP, 16'h7FFF, 1'b1, 16'h7FFF, 16'h0000},
		// One count across the wrap point: a minimum step that overshoots.
		'{ROW_WORD, REG_DIVISOR, CMD_STEP, 16'h8000, 1'b0, 16'h0000, 16'h0000},
		'{ROW_WORD, REG_DIVISOR, CMD_LOAD, 16'h8000, 1'b1, 16'h8000, 16'h0000},
		'{ROW_WORD, REG_DIVISOR, CMD_STEP, 16'h7FFF, 1'b0, 16'h0000, 16'h0000},
		'{ROW_WORD, REG_DIVISOR, CMD_LOAD, 16'h0000, 1'b1, 16'h0000, 16'h0000},
		// Large differences in both directions hit the max step clamp.
		'{ROW_WORD, REG_DIVISOR, CMD_STEP, 16'h4E20, 1'b0, 16'h0000, 16'h0000},
		'{ROW_WORD, REG_DIVISOR, CMD_STEP, 16'hB1E0, 1'b0, 16'h0000, 16'h0000},
		'{ROW_WORD, REG_DIVISOR, CMD_STEP, 16'h5555, 1'b0, 16'h0000, 16'h0000},
		'{ROW_WORD, REG_DIVISOR, CMD_STEP, 16'hAAAA, 1'b0, 16'h0000, 16'h0000},
		'{ROW_WORD, REG_DIVISOR, CMD_LOAD, 16'h0000, 1'b1, 16'h0000, 16'h0000},
		// Small differences take the minimum step, with and without a snap, or a small quotient step.
		'{ROW_WORD, REG_DIVISOR, CMD_STEP, 16'h000A, 1'b0, 16'h0000, 16'h0000},
		'{ROW_WORD, REG_DIVISOR, CMD_STEP, 16'h0064, 1'b0, 16'h0000, 16'h0000},
		'{ROW_WORD, REG_DIVISOR, CMD_STEP, 16'hFFFD, 1'b0, 16'h0000, 16'h0000},
		// A zero divisor behaves like a divisor of one.
		'{ROW_CFG,  REG_DIVISOR, CMD_STEP, 16'h0000, 1'b0, 16'h0000, 16'h0000},
		'{ROW_WORD, REG_DIVISOR, CMD_LOAD, 16'h0000, 1'b1, 16'h0000, 16'h0000},
		'{ROW_WORD, REG_DIVISOR, CMD_STEP, 16'h012C, 1'b0, 16'h0000, 16'h0000},
		'{ROW_WORD, REG_DIVISOR, CMD_STEP, 16'h8000, 1'b0, 16'h0000, 16'h0000},
		// With a zero minimum step the small-quotient path does not move.
		'{ROW_CFG,  REG_DIVISOR, CMD_STEP, 16'h7FFF, 1'b0, 16'h0000, 16'h0000},
		'{ROW_CFG,  REG_MIN_STEP, CMD_STEP, 16'h0000, 1'b0, 16'h0000, 16'h0000},
		'{ROW_WORD, REG_DIVISOR, CMD_STEP, 16'h03E8, 1'b0, 16'h0000, 16'h0000},
		// A huge minimum step wraps around the circle before the snap test.
		'{ROW_CFG,  REG_MAX_STEP, CMD_STEP, 16'h0000, 1'b0, 16'h0000, 16'h0000},
		'{ROW_CFG,  REG_MIN_STEP, CMD_STEP, 16'h7FFF, 1'b0, 16'h0000, 16'h0000},
		'{ROW_WORD, REG_DIVISOR, CMD_LOAD, 16'h0000, 1'b1, 16'h0000, 16'h0000},
		'{ROW_WORD, REG_DIVISOR, CMD_STEP, 16'h0064, 1'b0, 16'h0000, 16'h0000},
		'{ROW_WORD, REG_DIVISOR, CMD_STEP, 16'h8000, 1'b0, 16'h0000, 16'h0000},
		// A zero max step freezes the proportional path.
		'{ROW_CFG,  REG_DIVISOR, CMD_STEP, 16'h0001, 1'b0, 16'h0000, 16'h0000},
		'{ROW_CFG,  REG_MIN_STEP, CMD_STEP, 16'h0002, 1'b0, 16'h0000, 16'h0000},
		'{ROW_WORD, REG_DIVISOR, CMD_STEP, 16'h03E8, 1'b0, 16'h0000, 16'h0000}
	};

	angle_approach_wrapping dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.cmd       (cmd),
		.value     (value),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.new_angle (new_angle),
		.remaining (remaining)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Works out the result word for one input word, from the given angle and
	// the register copies. All angle arithmetic wraps at 16 bits.
	function automatic angle_word_t approach_angle(input logic [ANGLE_W-1:0] start,
			input logic op, input logic [ANGLE_W-1:0] target);
		angle_word_t result;
		logic [ANGLE_W-1:0] cur;
		logic signed [ANGLE_W-1:0] diff;
		logic signed [ANGLE_W-1:0] diff_after;
		int d;
		int dv;
		int q;
		int lim;
		int s;
		cur = start;
		if (op == CMD_LOAD) begin
			cur = target;
		end else if (cur != target) begin
			diff = target - cur;
			d = diff;
			dv = (div_reg == '0) ? 1 : int'(div_reg);
			// SystemVerilog integer division truncates toward zero.
			q = d / dv;
			lim = int'(min_reg);
			if (q <= lim && q >= -lim) begin
				// Fixed step toward the target; snap if it reaches or passes it.
				if (d < 0) begin
					cur = cur - ANGLE_W'(min_reg);
					diff_after = target - cur;
					if (diff_after >= 0)
						cur = target;
				end else begin
					cur = cur + ANGLE_W'(min_reg);
					diff_after = target - cur;
					if (diff_after < 1)
						cur = target;
				end
			end else begin
				s = q;
				if (s > int'(max_reg))
					s = int'(max_reg);
				if (s < -int'(max_reg))
					s = -int'(max_reg);
				cur = cur + s[ANGLE_W-1:0];
			end
		end
		result.angle = cur;
		result.rem = (op == CMD_LOAD) ? '0 : target - cur;
		return result;
	endfunction

	task automatic report_mismatch(input string what);
		$display("MISMATCH at cycle %0d: %s", cycle_count, what);
		mismatches++;
	endtask

	// Scoreboard. Outputs are sampled at the rising edge; an outgoing word is
	// retired before a word accepted at the same edge is predicted, since the
	// new word can never be the one coming out.
	always @(posedge clk) begin
		angle_word_t want;
		angle_word_t pred;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				results_seen++;
				if (pending_words.size() == 0) begin
					report_mismatch($sformatf("result word (%0d, %0d) with nothing pending",
						new_angle, remaining));
				end else begin
					want = pending_words.pop_front();
					if (new_angle !== want.angle)
						report_mismatch($sformatf("new_angle %0d, expected %0d",
							new_angle, $signed(want.angle)));
					if (remaining !== want.rem)
						report_mismatch($sformatf("remaining %0d, expected %0d",
							remaining, $signed(want.rem)));
				end
			end
			if (in_valid && in_ready) begin
				pred = approach_angle(model_angle, cmd, value);
				model_angle = pred.angle;
				if (cmd == CMD_LOAD)
					loads_done++;
				else
					steps_done++;
				pending_words.push_back(typed_now ? typed_word : pred);
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Timed out after %0d cycles with %0d words pending.",
				cycle_count, pending_words.size());
			$display("FAIL angle_approach_wrapping");
			$finish;
		end
	end

	// Receiver. Each word gets its own random stall, except in stretches where
	// idling is switched off. Once, it holds off for a long stretch so that the
	// block fills up and stops taking input while the sender keeps offering.
	initial begin
		int stall;
		@(negedge clk);
		forever begin
			if ($urandom_range(0, 39) == 0)
				rx_idle = !rx_idle;
			stall = rx_idle ? $urandom_range(0, 14) : 0;
			if (!hold_done && results_seen >= HOLD_AFTER) begin
				stall = HOLD_CYCLES;
				hold_done = 1'b1;
			end
			if (stall != 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!(out_valid && out_ready));
			@(negedge clk);
		end
	end

	// Offers one word and returns at the falling edge after it is taken, with
	// in_valid still high. The caller either offers the next word or lowers it
	// in that same step, so in_valid never gets two assignments at once.
	task automatic send_word(input logic op, input logic [ANGLE_W-1:0] data,
			input logic typed, input logic [ANGLE_W-1:0] angle,
			input logic [ANGLE_W-1:0] rem);
		int gap;
		gap = tx_idle ? $urandom_range(0, 14) : 0;
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		cmd <= op;
		value <= data;
		typed_now = typed;
		typed_word.angle = angle;
		typed_word.rem = rem;
		do @(posedge clk); while (!(in_valid && in_ready));
		@(negedge clk);
	endtask

	// Stops offering and waits until every result owed has come back. Every
	// word yields a result, so the block is idle once nothing is pending.
	task automatic drain_words();
		in_valid <= 1'b0;
		do @(negedge clk); while (pending_words.size() != 0);
	endtask

	// Register writes only happen while the block is idle. Our copy is updated
	// along with the write.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		case (idx)
			REG_DIVISOR:  div_reg = data;
			REG_MAX_STEP: max_reg = data;
			REG_MIN_STEP: min_reg = data;
			default: ;
		endcase
		cfg_writes++;
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	task automatic set_config(input logic [CFG_W-1:0] dv, input logic [CFG_W-1:0] mx,
			input logic [CFG_W-1:0] mn);
		drain_words();
		write_reg(REG_DIVISOR, dv);
		write_reg(REG_MAX_STEP, mx);
		write_reg(REG_MIN_STEP, mn);
		settings_used++;
	endtask

	initial begin
		logic [CFG_W-1:0] dv;
		logic [CFG_W-1:0] mx;
		logic [CFG_W-1:0] mn;
		logic [ANGLE_W-1:0] target;
		logic [ANGLE_W-1:0] last_target;
		logic op;

		// Every input is known from time zero, while reset is held low.
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_DIVISOR;
		cfg_wdata = '0;
		in_valid = 1'b0;
		cmd = CMD_STEP;
		value = '0;
		last_target = '0;
		repeat (9) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed part: walk the script. Register rows first let the block
		// finish whatever it holds.
		foreach (script[i]) begin
			if (script[i].kind == ROW_CFG) begin
				drain_words();
				write_reg(script[i].idx, script[i].data[CFG_W-1:0]);
			end else begin
				send_word(script[i].op, script[i].data, script[i].typed,
					script[i].angle, script[i].rem);
			end
		end
		typed_now = 1'b0;
		settings_used++;

		// Random part. The first setting is the reset values, the next three the
		// corners of the register space; the rest are drawn, mostly with small divisors
		// and minimum steps so that every path of the step logic sees traffic.
		for (int ph = 0; ph < NUM_SETTINGS; ph++) begin
			case (ph)
				0: begin dv = DIVISOR_RST; mx = MAX_STEP_RST; mn = MIN_STEP_RST; end
				1: begin dv = 15'd1; mx = 15'h7FFF; mn = 15'd0; end
				2: begin dv = 15'h7FFF; mx = 15'd0; mn = 15'h7FFF; end
				3: begin dv = 15'd0; mx = 15'h7FFF; mn = 15'h7FFF; end
				default: begin
					case ($urandom_range(0, 2))
						0: dv = CFG_W'($urandom_range(1, 8));
						1: dv = CFG_W'($urandom_range(1, 512));
						default: dv = CFG_W'($urandom_range(0, 32767));
					endcase
					mx = ($urandom_range(0, 1) != 0) ? CFG_W'($urandom_range(0, 2048))
						: CFG_W'($urandom_range(0, 32767));
					mn = ($urandom_range(0, 3) != 0) ? CFG_W'($urandom_range(0, 64))
						: CFG_W'($urandom_range(0, 32767));
				end
			endcase
			set_config(dv, mx, mn);

			for (int n = 0; n < WORDS_PER_SETTING; n++) begin
				if ($urandom_range(0, 39) == 0)
					tx_idle = !tx_idle;
				// Once, the sender stops midway and lets every result come home.
				if (ph == 6 && n == WORDS_PER_SETTING / 2)
					drain_words();
				op = ($urandom_range(0, 9) == 0) ? CMD_LOAD : CMD_STEP;
				// Repeating the last target walks the angle all the way in,
				// through the clamp, the minimum step and the final snap.
				case ($urandom_range(0, 9))
					0, 1: target = ANGLE_W'($urandom);
					2, 3: target = model_angle + ANGLE_W'($urandom_range(0, 255)) - 16'd128;
					4: target = model_angle + 16'h8000 + ANGLE_W'($urandom_range(0, 7)) - 16'd4;
					5, 6, 7, 8: target = last_target;
					default: begin
						case ($urandom_range(0, 3))
							0: target = 16'h7FFF;
							1: target = 16'h8000;
							2: target = 16'h0000;
							default: target = 16'hFFFF;
						endcase
					end
				endcase
				if (op == CMD_STEP)
					last_target = target;
				send_word(op, target, 1'b0, '0, '0);
			end
		end

		drain_words();
		repeat (TAIL_CYCLES) @(negedge clk);

		$display("Ran %0d loads and %0d steps through %0d register settings (%0d writes).",
			loads_done, steps_done, settings_used, cfg_writes);
		$display("Checked %0d result words, %0d mismatches.", results_seen, mismatches);
		if (mismatches == 0 && pending_words.size() == 0) begin
			$display("PASS angle_approach_wrapping");
		end else begin
			$display("FAIL angle_approach_wrapping");
		end
		$finish;
	end

endmodule
